// ----- hw/rtl/cfap_pkg.sv -----
// ----------------------------------------------------------------------------
// cfap_pkg
// Shared types, constants and tables of the corner fillet arc point generator.
// ----------------------------------------------------------------------------
`default_nettype none

package cfap_pkg;

  localparam int unsigned COORD_W     = 16;
  localparam int unsigned RADIUS_W    = 5;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 5'd10;

  localparam logic [31:0] GAIN_Q30    = 32'd652032874;
  localparam logic [26:0] TWO_PI_Q24  = 27'd105414357;
  localparam logic [31:0] CENTRE_MAX  = 32'h7FFF_FFFF;
  localparam logic [8:0]  MIN_SAMPLES = 9'd5;
  localparam logic [8:0]  MAX_SAMPLES = 9'd64;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_DEGEN   = 2'd1,
    STATUS_ACW     = 2'd2,
    STATUS_OVER_PI = 2'd3
  } status_e;

  typedef enum logic [5:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_PROD_CROSS,
    CMD_SUM_CROSS,
    CMD_PROD_LEN,
    CMD_SUM_LEN,
    CMD_STATUS,
    CMD_CLAMP,
    CMD_VEC_T,
    CMD_VEC_P,
    CMD_ITER,
    CMD_SAVE_T,
    CMD_SAVE_PHI,
    CMD_RT,
    CMD_NLO,
    CMD_NHI,
    CMD_NSET,
    CMD_ROT_HALF,
    CMD_SAVE_COSH,
    CMD_DIV_D,
    CMD_DIV_ITER,
    CMD_SAVE_D,
    CMD_ROT_MID,
    CMD_SAVE_MID,
    CMD_CX_MUL,
    CMD_CX_SET,
    CMD_CY_MUL,
    CMD_CY_SET,
    CMD_DIV_A,
    CMD_ROT_PT,
    CMD_PT_MUL,
    CMD_EMIT_PT
  } cmd_e;

  typedef enum logic [5:0] {
    ST_IDLE, ST_PCROSS, ST_SCROSS, ST_PLEN, ST_SLEN, ST_CHECK, ST_STATUS,
    ST_CLAMP, ST_VT, ST_VT_IT, ST_ST, ST_VP, ST_VP_IT, ST_SP, ST_RT,
    ST_NLO, ST_NHI, ST_NSET, ST_RH, ST_RH_IT, ST_SCOSH, ST_DD, ST_DD_IT,
    ST_SD, ST_RM, ST_RM_IT, ST_SM, ST_CXM, ST_CXS, ST_CYM, ST_CYS,
    ST_DA, ST_DA_IT, ST_RP, ST_RP_IT, ST_PM, ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic cr_zero;
    logic cr_pos;
    logic clamp_done;
    logic iter_last;
    logic div_last;
    logic pt_last;
    logic out_free;
  } dp_stat_t;

  // arctan(2^-i) as binary angle, full turn = 2^32
  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cfap_intf.sv -----
// ----------------------------------------------------------------------------
// cfap channel interfaces
// Valid/ready channels for vertex words, arc point words and the radius write.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfap_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] prev_x;
  logic signed [15:0] prev_y;
  logic signed [15:0] corner_x;
  logic signed [15:0] corner_y;
  logic signed [15:0] next_x;
  logic signed [15:0] next_y;
  modport source (output valid, prev_x, prev_y, corner_x, corner_y, next_x, next_y,
                  input ready);
  modport sink   (input valid, prev_x, prev_y, corner_x, corner_y, next_x, next_y,
                  output ready);
endinterface

interface cfap_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic               point_valid;
  logic [1:0]         status;
  logic               last;
  modport source (output valid, point_x, point_y, point_valid, status, last,
                  input ready);
  modport sink   (input valid, point_x, point_y, point_valid, status, last,
                  output ready);
endinterface

interface cfap_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] corner_radius;
  modport source (output valid, corner_radius, input ready);
  modport sink   (input valid, corner_radius, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/cfap_ctrl.sv -----
// ----------------------------------------------------------------------------
// cfap_ctrl
// Sequencer: steps the datapath through setup, CORDIC, division and emission.
// ----------------------------------------------------------------------------
`default_nettype none

module cfap_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire cfap_pkg::dp_stat_t stat_i,
  output cfap_pkg::cmd_e         cmd_o
);

  cfap_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cfap_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = cfap_pkg::CMD_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      cfap_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = cfap_pkg::CMD_LOAD;
          state_d = cfap_pkg::ST_PCROSS;
        end
      end
      cfap_pkg::ST_PCROSS: begin
        cmd_o   = cfap_pkg::CMD_PROD_CROSS;
        state_d = cfap_pkg::ST_SCROSS;
      end
      cfap_pkg::ST_SCROSS: begin
        cmd_o   = cfap_pkg::CMD_SUM_CROSS;
        state_d = cfap_pkg::ST_PLEN;
      end
      cfap_pkg::ST_PLEN: begin
        cmd_o   = cfap_pkg::CMD_PROD_LEN;
        state_d = cfap_pkg::ST_SLEN;
      end
      cfap_pkg::ST_SLEN: begin
        cmd_o   = cfap_pkg::CMD_SUM_LEN;
        state_d = cfap_pkg::ST_CHECK;
      end
      cfap_pkg::ST_CHECK: begin
        if (stat_i.cr_zero || stat_i.cr_pos) begin
          state_d = cfap_pkg::ST_STATUS;
        end else begin
          state_d = cfap_pkg::ST_CLAMP;
        end
      end
      cfap_pkg::ST_STATUS: begin
        if (stat_i.out_free) begin
          cmd_o   = cfap_pkg::CMD_STATUS;
          state_d = cfap_pkg::ST_IDLE;
        end
      end
      cfap_pkg::ST_CLAMP: begin
        cmd_o = cfap_pkg::CMD_CLAMP;
        if (stat_i.clamp_done) begin
          state_d = cfap_pkg::ST_VT;
        end
      end
      cfap_pkg::ST_VT: begin
        cmd_o   = cfap_pkg::CMD_VEC_T;
        state_d = cfap_pkg::ST_VT_IT;
      end
      cfap_pkg::ST_VT_IT: begin
        cmd_o = cfap_pkg::CMD_ITER;
        if (stat_i.iter_last) state_d = cfap_pkg::ST_ST;
      end
      cfap_pkg::ST_ST: begin
        cmd_o   = cfap_pkg::CMD_SAVE_T;
        state_d = cfap_pkg::ST_VP;
      end
      cfap_pkg::ST_VP: begin
        cmd_o   = cfap_pkg::CMD_VEC_P;
        state_d = cfap_pkg::ST_VP_IT;
      end
      cfap_pkg::ST_VP_IT: begin
        cmd_o = cfap_pkg::CMD_ITER;
        if (stat_i.iter_last) state_d = cfap_pkg::ST_SP;
      end
      cfap_pkg::ST_SP: begin
        cmd_o   = cfap_pkg::CMD_SAVE_PHI;
        state_d = cfap_pkg::ST_RT;
      end
      cfap_pkg::ST_RT: begin
        cmd_o   = cfap_pkg::CMD_RT;
        state_d = cfap_pkg::ST_NLO;
      end
      cfap_pkg::ST_NLO: begin
        cmd_o   = cfap_pkg::CMD_NLO;
        state_d = cfap_pkg::ST_NHI;
      end
      cfap_pkg::ST_NHI: begin
        cmd_o   = cfap_pkg::CMD_NHI;
        state_d = cfap_pkg::ST_NSET;
      end
      cfap_pkg::ST_NSET: begin
        cmd_o   = cfap_pkg::CMD_NSET;
        state_d = cfap_pkg::ST_RH;
      end
      cfap_pkg::ST_RH: begin
        cmd_o   = cfap_pkg::CMD_ROT_HALF;
        state_d = cfap_pkg::ST_RH_IT;
      end
      cfap_pkg::ST_RH_IT: begin
        cmd_o = cfap_pkg::CMD_ITER;
        if (stat_i.iter_last) state_d = cfap_pkg::ST_SCOSH;
      end
      cfap_pkg::ST_SCOSH: begin
        cmd_o   = cfap_pkg::CMD_SAVE_COSH;
        state_d = cfap_pkg::ST_DD;
      end
      cfap_pkg::ST_DD: begin
        cmd_o   = cfap_pkg::CMD_DIV_D;
        state_d = cfap_pkg::ST_DD_IT;
      end
      cfap_pkg::ST_DD_IT: begin
        cmd_o = cfap_pkg::CMD_DIV_ITER;
        if (stat_i.div_last) state_d = cfap_pkg::ST_SD;
      end
      cfap_pkg::ST_SD: begin
        cmd_o   = cfap_pkg::CMD_SAVE_D;
        state_d = cfap_pkg::ST_RM;
      end
      cfap_pkg::ST_RM: begin
        cmd_o   = cfap_pkg::CMD_ROT_MID;
        state_d = cfap_pkg::ST_RM_IT;
      end
      cfap_pkg::ST_RM_IT: begin
        cmd_o = cfap_pkg::CMD_ITER;
        if (stat_i.iter_last) state_d = cfap_pkg::ST_SM;
      end
      cfap_pkg::ST_SM: begin
        cmd_o   = cfap_pkg::CMD_SAVE_MID;
        state_d = cfap_pkg::ST_CXM;
      end
      cfap_pkg::ST_CXM: begin
        cmd_o   = cfap_pkg::CMD_CX_MUL;
        state_d = cfap_pkg::ST_CXS;
      end
      cfap_pkg::ST_CXS: begin
        cmd_o   = cfap_pkg::CMD_CX_SET;
        state_d = cfap_pkg::ST_CYM;
      end
      cfap_pkg::ST_CYM: begin
        cmd_o   = cfap_pkg::CMD_CY_MUL;
        state_d = cfap_pkg::ST_CYS;
      end
      cfap_pkg::ST_CYS: begin
        cmd_o   = cfap_pkg::CMD_CY_SET;
        state_d = cfap_pkg::ST_DA;
      end
      cfap_pkg::ST_DA: begin
        cmd_o   = cfap_pkg::CMD_DIV_A;
        state_d = cfap_pkg::ST_DA_IT;
      end
      cfap_pkg::ST_DA_IT: begin
        cmd_o = cfap_pkg::CMD_DIV_ITER;
        if (stat_i.div_last) state_d = cfap_pkg::ST_RP;
      end
      cfap_pkg::ST_RP: begin
        cmd_o   = cfap_pkg::CMD_ROT_PT;
        state_d = cfap_pkg::ST_RP_IT;
      end
      cfap_pkg::ST_RP_IT: begin
        cmd_o = cfap_pkg::CMD_ITER;
        if (stat_i.iter_last) state_d = cfap_pkg::ST_PM;
      end
      cfap_pkg::ST_PM: begin
        cmd_o   = cfap_pkg::CMD_PT_MUL;
        state_d = cfap_pkg::ST_EMIT;
      end
      cfap_pkg::ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o   = cfap_pkg::CMD_EMIT_PT;
          state_d = stat_i.pt_last ? cfap_pkg::ST_IDLE : cfap_pkg::ST_DA;
        end
      end
      default: begin
        state_d = cfap_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/cfap_dp.sv -----
// ----------------------------------------------------------------------------
// cfap_dp
// Datapath: edge products, radius clamp, shared CORDIC, shared restoring
// divider, centre and point arithmetic, output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module cfap_dp #(
  parameter int unsigned COORD_FRAC_BITS   = 4,
  parameter int unsigned CORDIC_ITERATIONS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cfap_pkg::cmd_e     cmd_i,
  output cfap_pkg::dp_stat_t      stat_o,
  input  wire logic signed [15:0] prev_x_i,
  input  wire logic signed [15:0] prev_y_i,
  input  wire logic signed [15:0] corner_x_i,
  input  wire logic signed [15:0] corner_y_i,
  input  wire logic signed [15:0] next_x_i,
  input  wire logic signed [15:0] next_y_i,
  input  wire logic [4:0]         radius_i,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic signed [15:0]      point_x_o,
  output logic signed [15:0]      point_y_o,
  output logic                    point_valid_o,
  output logic [1:0]              status_o,
  output logic                    last_o
);

  localparam int unsigned RQW  = 5 + COORD_FRAC_BITS;
  localparam int unsigned EW   = 6 + COORD_FRAC_BITS;
  localparam int unsigned DW   = RQW + 32;
  localparam int unsigned CW   = 38;
  localparam int unsigned ZW   = 34;
  localparam int unsigned CNTW = $clog2(DW + 1);

  function automatic logic signed [63:0] rnd30(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [63:0] m;
    mag = v[63] ? 64'(-v) : 64'(v);
    m   = (mag + 64'd536870912) >> 30;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
    logic signed [15:0] r;
    if (v > 36'sd32767) r = 16'sh7FFF;
    else if (v < -36'sd32768) r = -16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  // payload registers
  logic signed [15:0]   cx_q, cx_d, cy_q, cy_d;
  logic signed [16:0]   bax_q, bax_d, bay_q, bay_d, bcx_q, bcx_d, bcy_q, bcy_d;
  logic signed [33:0]   p0_q, p0_d, p1_q, p1_d, p2_q, p2_d, p3_q, p3_d;
  logic signed [34:0]   cr_q, cr_d, dt_q, dt_d;
  logic [33:0]          dab_q, dab_d, dbc_q, dbc_d;
  logic [4:0]           r_q, r_d;
  logic [30:0]          t_q, t_d;
  logic [31:0]          phi_q, phi_d;
  logic [35:0]          rt_q, rt_d;
  logic [42:0]          nlo_q, nlo_d;
  logic [46:0]          nhi_q, nhi_d;
  logic [6:0]           n_q, n_d;
  logic [5:0]           i_q, i_d;
  logic [31:0]          cosh_q, cosh_d, d_q, d_d;
  logic signed [31:0]   cm_q, cm_d, sm_q, sm_d;
  logic signed [63:0]   prod_q, prod_d, prod2_q, prod2_d;
  logic signed [34:0]   cirx_q, cirx_d, ciry_q, ciry_d;
  logic signed [CW-1:0] kx_q, kx_d, ky_q, ky_d;
  logic signed [ZW-1:0] kz_q, kz_d;
  logic                 kvec_q, kvec_d, kflip_q, kflip_d;
  logic [CNTW-1:0]      cnt_q, cnt_d;
  logic [DW-1:0]        dq_q, dq_d;
  logic [31:0]          rm_q, rm_d, dv_q, dv_d;
  logic signed [15:0]   opx_q, opx_d, opy_q, opy_d;
  logic                 opv_q, opv_d, olast_q, olast_d;
  cfap_pkg::status_e    ost_q, ost_d;
  logic                 full_q, full_d;

  // helpers
  logic [RQW-1:0]       rq;
  logic [EW-1:0]        e_val;
  logic [2*EW-1:0]      e_sq;
  logic                 fits;
  logic [4:0]           sh;
  logic signed [CW-1:0] kdx, kdy, vsx, vsy;
  logic signed [ZW-1:0] katan;
  logic                 kpos;
  logic signed [CW-1:0] cres, sres;
  logic [31:0]          rot_a, rot_a2;
  logic                 rot_flip;
  logic [32:0]          dtmp;
  logic                 dge;
  logic [36:0]          ti;
  logic [63:0]          nsum;
  logic [8:0]           n0;
  logic signed [63:0]   op_a, op_b, op_c;
  logic                 out_free;

  assign rq       = RQW'(r_q) << COORD_FRAC_BITS;
  assign e_val    = EW'(6'({r_q, 1'b0} - 6'd1)) << COORD_FRAC_BITS;
  assign e_sq     = e_val * e_val;
  assign fits     = (34'(e_sq) <= dab_q) && (34'(e_sq) <= dbc_q);
  assign sh       = cnt_q[4:0];
  assign kdx      = ky_q >>> sh;
  assign kdy      = kx_q >>> sh;
  assign katan    = ZW'(cfap_pkg::atan_lut(sh));
  assign kpos     = kvec_q ? !(ky_q > 0) : (kz_q >= 0);
  assign cres     = kflip_q ? -kx_q : kx_q;
  assign sres     = kflip_q ? -ky_q : ky_q;
  assign dtmp     = {rm_q, dq_q[DW-1]};
  assign dge      = dtmp >= {1'b0, dv_q};
  assign ti       = 37'(t_q) * 37'(i_q);
  assign nsum     = {1'b0, nhi_q, 16'b0} + {21'b0, nlo_q};
  assign n0       = {1'b0, nsum[63:56]} + 9'd2;
  assign out_free = !full_q || out_ready_i;

  always_comb begin
    case (cmd_i)
      cfap_pkg::CMD_ROT_HALF: rot_a = {2'b0, t_q[30:1]};
      cfap_pkg::CMD_ROT_MID:  rot_a = phi_q + {2'b0, t_q[30:1]};
      default:                rot_a = phi_q + dq_q[31:0];
    endcase
    rot_flip = rot_a[31] ^ rot_a[30];
    rot_a2   = rot_flip ? rot_a - 32'h8000_0000 : rot_a;
    if (cmd_i == cfap_pkg::CMD_VEC_T) begin
      vsx = -CW'(dt_q);
      vsy = -CW'(cr_q);
    end else begin
      vsx = CW'(bax_q);
      vsy = CW'(bay_q);
    end
  end

  always_comb begin
    cx_d = cx_q;   cy_d = cy_q;
    bax_d = bax_q; bay_d = bay_q; bcx_d = bcx_q; bcy_d = bcy_q;
    p0_d = p0_q;   p1_d = p1_q;   p2_d = p2_q;   p3_d = p3_q;
    cr_d = cr_q;   dt_d = dt_q;   dab_d = dab_q; dbc_d = dbc_q;
    r_d = r_q;     t_d = t_q;     phi_d = phi_q; rt_d = rt_q;
    nlo_d = nlo_q; nhi_d = nhi_q; n_d = n_q;     i_d = i_q;
    cosh_d = cosh_q; d_d = d_q;   cm_d = cm_q;   sm_d = sm_q;
    prod_d = prod_q; prod2_d = prod2_q; cirx_d = cirx_q; ciry_d = ciry_q;
    kx_d = kx_q;   ky_d = ky_q;   kz_d = kz_q;   kvec_d = kvec_q; kflip_d = kflip_q;
    cnt_d = cnt_q; dq_d = dq_q;   rm_d = rm_q;   dv_d = dv_q;
    opx_d = opx_q; opy_d = opy_q; opv_d = opv_q; ost_d = ost_q; olast_d = olast_q;
    full_d = full_q && !out_ready_i;
    op_a = '0;
    op_b = '0;
    op_c = '0;
    case (cmd_i)
      cfap_pkg::CMD_LOAD: begin
        cx_d  = corner_x_i;
        cy_d  = corner_y_i;
        bax_d = 17'(prev_x_i) - 17'(corner_x_i);
        bay_d = 17'(prev_y_i) - 17'(corner_y_i);
        bcx_d = 17'(next_x_i) - 17'(corner_x_i);
        bcy_d = 17'(next_y_i) - 17'(corner_y_i);
        r_d   = radius_i;
      end
      cfap_pkg::CMD_PROD_CROSS: begin
        p0_d = 34'(bax_q) * 34'(bcy_q);
        p1_d = 34'(bay_q) * 34'(bcx_q);
        p2_d = 34'(bax_q) * 34'(bcx_q);
        p3_d = 34'(bay_q) * 34'(bcy_q);
      end
      cfap_pkg::CMD_SUM_CROSS: begin
        cr_d = 35'(p0_q) - 35'(p1_q);
        dt_d = 35'(p2_q) + 35'(p3_q);
      end
      cfap_pkg::CMD_PROD_LEN: begin
        p0_d = 34'(bax_q) * 34'(bax_q);
        p1_d = 34'(bay_q) * 34'(bay_q);
        p2_d = 34'(bcx_q) * 34'(bcx_q);
        p3_d = 34'(bcy_q) * 34'(bcy_q);
      end
      cfap_pkg::CMD_SUM_LEN: begin
        dab_d = 34'(p0_q) + 34'(p1_q);
        dbc_d = 34'(p2_q) + 34'(p3_q);
      end
      cfap_pkg::CMD_STATUS: begin
        opx_d   = '0;
        opy_d   = '0;
        opv_d   = 1'b0;
        ost_d   = (cr_q == '0) ? cfap_pkg::STATUS_DEGEN : cfap_pkg::STATUS_ACW;
        olast_d = 1'b1;
        full_d  = 1'b1;
      end
      cfap_pkg::CMD_CLAMP: begin
        if (r_q != '0 && !fits) r_d = r_q - 5'd1;
      end
      cfap_pkg::CMD_VEC_T, cfap_pkg::CMD_VEC_P: begin
        kx_d    = vsx[CW-1] ? -vsx : vsx;
        ky_d    = vsx[CW-1] ? -vsy : vsy;
        kz_d    = vsx[CW-1] ? ZW'(34'h0_8000_0000) : '0;
        kvec_d  = 1'b1;
        kflip_d = 1'b0;
        cnt_d   = '0;
      end
      cfap_pkg::CMD_ROT_HALF, cfap_pkg::CMD_ROT_MID, cfap_pkg::CMD_ROT_PT: begin
        kx_d    = CW'(cfap_pkg::GAIN_Q30);
        ky_d    = '0;
        kz_d    = ZW'($signed(rot_a2));
        kvec_d  = 1'b0;
        kflip_d = rot_flip;
        cnt_d   = '0;
      end
      cfap_pkg::CMD_ITER: begin
        if (kpos) begin
          kx_d = kx_q - kdx;
          ky_d = ky_q + kdy;
          kz_d = kz_q - katan;
        end else begin
          kx_d = kx_q + kdx;
          ky_d = ky_q - kdy;
          kz_d = kz_q + katan;
        end
        cnt_d = cnt_q + 1'b1;
      end
      cfap_pkg::CMD_SAVE_T: begin
        t_d = kz_q[31] ? '0 : kz_q[30:0];
      end
      cfap_pkg::CMD_SAVE_PHI: begin
        phi_d = kz_q[31:0] + 32'h4000_0000;
      end
      cfap_pkg::CMD_RT: begin
        rt_d = 36'(r_q) * 36'(t_q);
      end
      cfap_pkg::CMD_NLO: begin
        nlo_d = 43'(rt_q[15:0]) * 43'(cfap_pkg::TWO_PI_Q24);
      end
      cfap_pkg::CMD_NHI: begin
        nhi_d = 47'(rt_q[35:16]) * 47'(cfap_pkg::TWO_PI_Q24);
      end
      cfap_pkg::CMD_NSET: begin
        if (n0 < cfap_pkg::MIN_SAMPLES) n_d = 7'(cfap_pkg::MIN_SAMPLES);
        else if (n0 > cfap_pkg::MAX_SAMPLES) n_d = 7'(cfap_pkg::MAX_SAMPLES);
        else n_d = n0[6:0];
        i_d = 6'd1;
      end
      cfap_pkg::CMD_SAVE_COSH: begin
        cosh_d = ($signed(cres[31:0]) < 32'sd1) ? 32'd1 : cres[31:0];
      end
      cfap_pkg::CMD_DIV_D: begin
        dq_d  = (DW'(rq) << 30) + DW'(cosh_q >> 1);
        dv_d  = cosh_q;
        rm_d  = '0;
        cnt_d = '0;
      end
      cfap_pkg::CMD_DIV_A: begin
        dq_d  = DW'(ti);
        dv_d  = 32'(n_q);
        rm_d  = '0;
        cnt_d = '0;
      end
      cfap_pkg::CMD_DIV_ITER: begin
        rm_d  = dge ? 32'(dtmp - {1'b0, dv_q}) : dtmp[31:0];
        dq_d  = {dq_q[DW-2:0], dge};
        cnt_d = cnt_q + 1'b1;
      end
      cfap_pkg::CMD_SAVE_D: begin
        d_d = (dq_q > DW'(cfap_pkg::CENTRE_MAX)) ? cfap_pkg::CENTRE_MAX : dq_q[31:0];
      end
      cfap_pkg::CMD_SAVE_MID: begin
        cm_d = cres[31:0];
        sm_d = sres[31:0];
      end
      cfap_pkg::CMD_CX_MUL: begin
        op_a   = 64'($signed({1'b0, d_q}));
        op_b   = 64'(cm_q);
        prod_d = op_a * op_b;
      end
      cfap_pkg::CMD_CX_SET: begin
        cirx_d = 35'(cx_q) - 35'(rnd30(prod_q));
      end
      cfap_pkg::CMD_CY_MUL: begin
        op_a   = 64'($signed({1'b0, d_q}));
        op_b   = 64'(sm_q);
        prod_d = op_a * op_b;
      end
      cfap_pkg::CMD_CY_SET: begin
        ciry_d = 35'(cy_q) - 35'(rnd30(prod_q));
      end
      cfap_pkg::CMD_PT_MUL: begin
        op_a    = 64'($signed({1'b0, rq}));
        op_b    = 64'($signed(cres[31:0]));
        op_c    = 64'($signed(sres[31:0]));
        prod_d  = op_a * op_b;
        prod2_d = op_a * op_c;
      end
      cfap_pkg::CMD_EMIT_PT: begin
        opx_d   = sat16(36'(cirx_q) + 36'(rnd30(prod_q)));
        opy_d   = sat16(36'(ciry_q) + 36'(rnd30(prod2_q)));
        opv_d   = 1'b1;
        ost_d   = cfap_pkg::STATUS_OK;
        olast_d = stat_o.pt_last;
        full_d  = 1'b1;
        i_d     = i_q + 6'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q <= cx_d;   cy_q <= cy_d;
    bax_q <= bax_d; bay_q <= bay_d; bcx_q <= bcx_d; bcy_q <= bcy_d;
    p0_q <= p0_d;   p1_q <= p1_d;   p2_q <= p2_d;   p3_q <= p3_d;
    cr_q <= cr_d;   dt_q <= dt_d;   dab_q <= dab_d; dbc_q <= dbc_d;
    r_q <= r_d;     t_q <= t_d;     phi_q <= phi_d; rt_q <= rt_d;
    nlo_q <= nlo_d; nhi_q <= nhi_d; n_q <= n_d;     i_q <= i_d;
    cosh_q <= cosh_d; d_q <= d_d;   cm_q <= cm_d;   sm_q <= sm_d;
    prod_q <= prod_d; prod2_q <= prod2_d; cirx_q <= cirx_d; ciry_q <= ciry_d;
    kx_q <= kx_d;   ky_q <= ky_d;   kz_q <= kz_d;   kvec_q <= kvec_d; kflip_q <= kflip_d;
    cnt_q <= cnt_d; dq_q <= dq_d;   rm_q <= rm_d;   dv_q <= dv_d;
    opx_q <= opx_d; opy_q <= opy_d; opv_q <= opv_d; ost_q <= ost_d; olast_q <= olast_d;
  end

  assign stat_o.cr_zero    = (cr_q == '0);
  assign stat_o.cr_pos     = !cr_q[34] && (cr_q != '0);
  assign stat_o.clamp_done = (r_q == '0) || fits;
  assign stat_o.iter_last  = (cnt_q == CNTW'(CORDIC_ITERATIONS - 1));
  assign stat_o.div_last   = (cnt_q == CNTW'(DW - 1));
  assign stat_o.pt_last    = (({1'b0, i_q} + 7'd1) == n_q);
  assign stat_o.out_free   = out_free;

  assign out_valid_o   = full_q;
  assign point_x_o     = opx_q;
  assign point_y_o     = opy_q;
  assign point_valid_o = opv_q;
  assign status_o      = ost_q;
  assign last_o        = olast_q;

endmodule

`default_nettype wire

// ----- hw/rtl/corner_fillet_arc_points.sv -----
// ----------------------------------------------------------------------------
// corner_fillet_arc_points
// Rounds a polygon corner into a circular arc and streams the arc points.
//
// in_i takes one word of three vertices (previous, corner, next, Q12.4).
// cfg_i writes the fillet radius in whole pixels; it is always ready. It is
// for the user to see that it is written only while the block is idle; the
// block itself does not enforce this. Reset puts the radius at 10. out_o
// gives N-1 point words per clockwise corner, last set on the final one, or
// a single status word for a degenerate or anticlockwise corner. One corner
// is processed at a time; in_i is ready only between corners. A clockwise
// corner has a setup (edge products, radius clamp, CORDIC, division and
// centre), then, per point, the bit-serial divider (F + 37 steps, F =
// COORD_FRAC_BITS) and the shared CORDIC (I steps, I = CORDIC_ITERATIONS).
// The output word register holds while out_o is stalled; the sequencer
// waits before writing the next word into it.
// ----------------------------------------------------------------------------
`default_nettype none

module corner_fillet_arc_points #(
  parameter int unsigned COORD_FRAC_BITS   = 4,
  parameter int unsigned CORDIC_ITERATIONS = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  cfap_cfg_if.sink    cfg_i,
  cfap_in_if.sink     in_i,
  cfap_out_if.source  out_o
);

  logic [cfap_pkg::RADIUS_W-1:0] radius_q, radius_d;
  cfap_pkg::cmd_e                cmd;
  cfap_pkg::dp_stat_t            stat;
  logic                          in_ready;

  assign cfg_i.ready = 1'b1;
  assign radius_d    = cfg_i.valid ? cfg_i.corner_radius : radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= cfap_pkg::RADIUS_RESET;
    end else begin
      radius_q <= radius_d;
    end
  end

  cfap_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  assign in_i.ready = in_ready;

  cfap_dp #(
    .COORD_FRAC_BITS   (COORD_FRAC_BITS),
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .prev_x_i      (in_i.prev_x),
    .prev_y_i      (in_i.prev_y),
    .corner_x_i    (in_i.corner_x),
    .corner_y_i    (in_i.corner_y),
    .next_x_i      (in_i.next_x),
    .next_y_i      (in_i.next_y),
    .radius_i      (radius_q),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .point_x_o     (out_o.point_x),
    .point_y_o     (out_o.point_y),
    .point_valid_o (out_o.point_valid),
    .status_o      (out_o.status),
    .last_o        (out_o.last)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken while a corner is in progress");

  a_load_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd == cfap_pkg::CMD_LOAD) |-> (in_i.valid && in_i.ready))
    else $error("datapath load without an accepted word");

  a_status_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.point_valid) |->
      (out_o.last && (out_o.status == cfap_pkg::STATUS_DEGEN ||
                      out_o.status == cfap_pkg::STATUS_ACW)))
    else $error("malformed status word");

  a_point_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.point_valid) |-> (out_o.status == cfap_pkg::STATUS_OK))
    else $error("point word with non-ok status");

endmodule

`default_nettype wire

// ----- tb/sv/corner_fillet_arc_points_tb.sv -----
// ----------------------------------------------------------------------------
// corner_fillet_arc_points_tb
// Self-checking bench: corners go in, the expected arc point words are
// computed by a CORDIC-based fixed-point predictor, and every output word is
// compared field by field in order, under several radius settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module corner_fillet_arc_points_tb;

  localparam int FRAC = 4;
  localparam int ITERS = 16;
  localparam longint CYCLE_LIMIT = 64'd3_000_000;

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic               pv;
    cfap_pkg::status_e  st;
    logic               lst;
  } arc_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cfap_cfg_if cfg_ch ();
  cfap_in_if  vtx_ch ();
  cfap_out_if arc_ch ();

  corner_fillet_arc_points #(
    .COORD_FRAC_BITS(FRAC),
    .CORDIC_ITERATIONS(ITERS)
  ) u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_i(cfg_ch.sink),
    .in_i(vtx_ch.sink),
    .out_o(arc_ch.source)
  );

  arc_word_t   arc_queue[$];
  logic [4:0]  radius_reg;
  int          src_idle_pct;
  int          snk_stall_pct;
  int          errors;
  int          words_checked;
  int          corners_sent;
  longint      cycles;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic longint sh_r(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint round_q(longint v, int s);
    longint h;
    h = longint'(1) << (s - 1);
    if (v >= 0) return (v + h) >>> s;
    return -(((-v) + h) >>> s);
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic void add_expected(arc_word_t w);
    arc_queue = {arc_queue, w};
  endfunction

  function automatic logic [31:0] angle_of(longint x, longint y);
    logic [31:0] z;
    longint dx, dy;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < ITERS; i++) begin
      dx = sh_r(y, i);
      dy = sh_r(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += cfap_pkg::atan_lut(i[4:0]);
      end else begin
        x -= dx; y += dy; z -= cfap_pkg::atan_lut(i[4:0]);
      end
    end
    return z;
  endfunction

  task automatic cos_sin(input logic [31:0] a, output longint c, output longint s);
    logic   flip;
    logic [31:0] t;
    longint x, y, z, dx, dy;
    t = a + 32'h4000_0000;
    flip = t[31];
    if (flip) a = a - 32'h8000_0000;
    x = cfap_pkg::GAIN_Q30;
    y = 0;
    z = a[31] ? longint'(a) - 64'sd4294967296 : longint'(a);
    for (int i = 0; i < ITERS; i++) begin
      dx = sh_r(y, i);
      dy = sh_r(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(cfap_pkg::atan_lut(i[4:0]));
      end else begin
        x += dx; y -= dy; z += longint'(cfap_pkg::atan_lut(i[4:0]));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic predict_arc(input logic signed [15:0] ax, ay, bx, by, cx2, cy2);
    longint one, cx, cy, bax, bay, bcx, bcy, cr, dt, dab, dbc, r, e, t, rq, d;
    longint cosh, sinh, cm, sm, cirx, ciry, c, s, n;
    logic [31:0] tu, phi1, half, a;
    logic [127:0] prod;
    arc_word_t w;
    one = longint'(1) << FRAC;
    cx = bx; cy = by;
    bax = ax - cx; bay = ay - cy;
    bcx = cx2 - cx; bcy = cy2 - cy;
    cr = bax * bcy - bay * bcx;
    dt = bax * bcx + bay * bcy;
    dab = bax * bax + bay * bay;
    dbc = bcx * bcx + bcy * bcy;
    r = radius_reg;
    w = '{px: 0, py: 0, pv: 1'b0, st: cfap_pkg::STATUS_DEGEN, lst: 1'b1};
    if (cr == 0) begin
      add_expected(w);
      return;
    end
    if (cr > 0) begin
      w.st = cfap_pkg::STATUS_ACW;
      add_expected(w);
      return;
    end
    while (r > 0) begin
      e = one * (2 * r - 1);
      if (e * e <= dab && e * e <= dbc) break;
      r--;
    end
    tu = angle_of(-dt, -cr);
    t = tu[31] ? 0 : longint'(tu);
    phi1 = angle_of(bax, bay) + 32'h4000_0000;
    prod = 128'(r) * 128'(t) * 128'(cfap_pkg::TWO_PI_Q24);
    n = longint'(prod >> 56) + 2;
    if (n < 5) n = 5;
    if (n > 64) n = 64;
    half = t[32:1];
    cos_sin(half, cosh, sinh);
    if (cosh < 1) cosh = 1;
    rq = r * one;
    d = ((rq <<< 30) + (cosh >>> 1)) / cosh;
    if (d > 64'sd2147483647) d = 64'sd2147483647;
    cos_sin(phi1 + half, cm, sm);
    cirx = cx - round_q(d * cm, 30);
    ciry = cy - round_q(d * sm, 30);
    for (longint i = 1; i < n; i++) begin
      a = phi1 + 32'((t * i) / n);
      cos_sin(a, c, s);
      w.px = 16'(clip16(cirx + round_q(rq * c, 30)));
      w.py = 16'(clip16(ciry + round_q(rq * s, 30)));
      w.pv = 1'b1;
      w.st = cfap_pkg::STATUS_OK;
      w.lst = (i == n - 1);
      add_expected(w);
    end
  endtask

  // output checker
  always @(posedge clk_i) begin
    arc_word_t got, want;
    if (rst_ni && arc_ch.valid && arc_ch.ready) begin
      got = '{px: arc_ch.point_x, py: arc_ch.point_y, pv: arc_ch.point_valid,
              st: cfap_pkg::status_e'(arc_ch.status), lst: arc_ch.last};
      if (arc_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word x=%0d y=%0d", got.px, got.py);
      end else begin
        want = arc_queue.pop_front();
        words_checked++;
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch exp x=%0d y=%0d pv=%0b st=%0d last=%0b",
                      " got x=%0d y=%0d pv=%0b st=%0d last=%0b"},
                     want.px, want.py, want.pv, want.st, want.lst,
                     got.px, got.py, got.pv, got.st, got.lst);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (snk_stall_pct > 0) arc_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    else arc_ch.ready <= 1'b1;
  end

  task automatic send_corner(input logic signed [15:0] ax, ay, bx, by, cx, cy);
    @(negedge clk_i);
    while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) @(negedge clk_i);
    vtx_ch.valid <= 1'b1;
    vtx_ch.prev_x <= ax; vtx_ch.prev_y <= ay;
    vtx_ch.corner_x <= bx; vtx_ch.corner_y <= by;
    vtx_ch.next_x <= cx; vtx_ch.next_y <= cy;
    predict_arc(ax, ay, bx, by, cx, cy);
    do @(posedge clk_i); while (!vtx_ch.ready);
    @(negedge clk_i);
    vtx_ch.valid <= 1'b0;
    corners_sent++;
  endtask

  task automatic drain();
    while (arc_queue.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic set_radius(input logic [4:0] r);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.corner_radius <= r;
    do @(posedge clk_i); while (!cfg_ch.ready);
    radius_reg = r;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] rnd_coord(int span);
    return 16'($signed($urandom_range(2 * span)) - span);
  endfunction

  // clockwise corner with random content around a random center
  task automatic send_cw_corner(input int span);
    logic signed [15:0] ax, ay, bx, by, cx, cy;
    bx = rnd_coord(span); by = rnd_coord(span);
    ax = bx + rnd_coord(span); ay = by + rnd_coord(span);
    cx = bx + rnd_coord(span); cy = by + rnd_coord(span);
    if ((longint'(ax - bx) * (cy - by) - longint'(ay - by) * (cx - bx)) > 0)
      send_corner(cx, cy, bx, by, ax, ay);
    else
      send_corner(ax, ay, bx, by, cx, cy);
  endtask

  task automatic test_reset_radius();
    send_corner(16'sd0, 16'sd800, 16'sd0, 16'sd0, 16'sd800, 16'sd0);
    send_corner(16'sd800, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd800);
  endtask

  task automatic test_special_cases();
    set_radius(5'd20);
    send_corner(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_corner(-16'sd100, 16'sd0, 16'sd0, 16'sd0, 16'sd100, 16'sd0);
    send_corner(16'sd100, 16'sd0, 16'sd0, 16'sd0, 16'sd100, 16'sd0);
    send_corner(16'sd0, 16'sd400, 16'sd0, 16'sd0, 16'sd400, 16'sd0);
    send_corner(16'sd0, 16'sd40, 16'sd0, 16'sd0, 16'sd40, 16'sd0);
    send_corner(16'sd1000, 16'sd1, 16'sd0, 16'sd0, 16'sd1000, 16'sd0);
    send_corner(-16'sd1000, -16'sd1, 16'sd0, 16'sd0, 16'sd1000, 16'sd0);
    send_corner(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000);
    send_corner(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_corner(16'sh7f00, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7f00);
    set_radius(5'd0);
    send_corner(16'sd0, 16'sd400, 16'sd0, 16'sd0, 16'sd400, 16'sd0);
    send_corner(16'sh5555, -16'sh2aaa, -16'sh1234, 16'sh4321, 16'sh0f0f, 16'sh7000);
    set_radius(5'd31);
    send_corner(16'sd0, 16'sd4000, 16'sd0, 16'sd0, 16'sd4000, 16'sd0);
  endtask

  task automatic test_random(input int count);
    int sel;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(9);
      if (sel < 7) send_cw_corner((sel < 4) ? 600 : 8000);
      else if (sel == 7) send_corner(16'($urandom), 16'($urandom), 16'($urandom),
                                     16'($urandom), 16'($urandom), 16'($urandom));
      else send_cw_corner(16000);
    end
  endtask

  task automatic test_idle_phases();
    int idle_tab[4] = '{0, 51, 0, 34};
    int stall_tab[4] = '{0, 0, 51, 34};
    logic [4:0] rad_tab[4] = '{5'd3, 5'd20, 5'd31, 5'd12};
    for (int p = 0; p < 4; p++) begin
      set_radius(rad_tab[p]);
      src_idle_pct = idle_tab[p];
      snk_stall_pct = stall_tab[p];
      test_random(35);
    end
    src_idle_pct = 0;
    snk_stall_pct = 0;
  endtask

  initial begin
    errors = 0; words_checked = 0; corners_sent = 0; cycles = 0;
    src_idle_pct = 0; snk_stall_pct = 0;
    radius_reg = cfap_pkg::RADIUS_RESET;
    vtx_ch.valid = 1'b0;
    vtx_ch.prev_x = '0; vtx_ch.prev_y = '0;
    vtx_ch.corner_x = '0; vtx_ch.corner_y = '0;
    vtx_ch.next_x = '0; vtx_ch.next_y = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.corner_radius = '0;
    arc_ch.ready = 1'b1;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);
    test_reset_radius();
    test_special_cases();
    test_idle_phases();
    set_radius(5'd1);
    test_random(12);
    drain();
    $display("corners sent: %0d, output words checked: %0d, radius 0..31", corners_sent,
             words_checked);
    $display("directed corners, then random clockwise/noise corners under four idle phases");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("errors: %0d", errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
hw/rtl/cfap_pkg.sv
hw/rtl/cfap_intf.sv
hw/rtl/cfap_ctrl.sv
hw/rtl/cfap_dp.sv
hw/rtl/corner_fillet_arc_points.sv
tb/sv/corner_fillet_arc_points_tb.sv
